/* design/lcalc_pkg.sv */
`default_nettype none
package lcalc_pkg;

    localparam int DEF_ENTRIES = 64;
    localparam int DEF_FRAC    = 16;
    localparam int COEF_BITS   = 24;
    localparam int CNT_W       = 16;
    localparam int LUX_W       = 27;
    localparam int BAND_W      = 3;
    localparam int KW          = 20;

    localparam logic [KW-1:0] K_B1_CH0 = 20'd510027;
    localparam logic [KW-1:0] K_B1_POW = 20'd1040187;
    localparam logic [KW-1:0] K_B2_CH0 = 20'd375810;
    localparam logic [KW-1:0] K_B2_CH1 = 20'd520094;
    localparam logic [KW-1:0] K_B3_CH0 = 20'd214748;
    localparam logic [KW-1:0] K_B3_CH1 = 20'd256691;
    localparam logic [KW-1:0] K_B4_CH0 = 20'd24495;
    localparam logic [KW-1:0] K_B4_CH1 = 20'd18790;

    localparam logic [BAND_W-1:0] BAND_ZERO = 3'd0;
    localparam logic [BAND_W-1:0] BAND_LOW  = 3'd1;
    localparam logic [BAND_W-1:0] BAND_MID  = 3'd2;
    localparam logic [BAND_W-1:0] BAND_HIGH = 3'd3;
    localparam logic [BAND_W-1:0] BAND_TOP  = 3'd4;
    localparam logic [BAND_W-1:0] BAND_OVER = 3'd5;

    localparam logic [LUX_W-1:0] LUX_MAX = {LUX_W{1'b1}};

    typedef struct packed {
        logic [CNT_W-1:0] broadband_count;
        logic [CNT_W-1:0] infrared_count;
    } sample_t;

    typedef struct packed {
        logic [LUX_W-1:0]  lux_value;
        logic [BAND_W-1:0] ratio_band;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0]  c0;
        logic [CNT_W-1:0]  c1;
        logic [BAND_W-1:0] band;
    } side_t;

    // shift-subtract division, elaboration use only
    function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int k = 63; k >= 0; k--) begin
            r = (r << 1) | ((n >> k) & 64'd1);
            if (r >= d) begin
                r = r - d;
                q = q | (64'd1 << k);
            end
        end
        return q;
    endfunction

    function automatic longint unsigned fifth_root(longint unsigned n);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned m;
        lo = 0;
        hi = 4096;
        for (int k = 0; k < 14; k++) begin
            if (lo < hi) begin
                m = (lo + hi + 64'd1) >> 1;
                if (m * m * m * m * m <= n)
                    lo = m;
                else
                    hi = m - 64'd1;
            end
        end
        return lo;
    endfunction

    // x^1.4 at x = i / (2n), as x * (x^2)^(1/5)
    function automatic longint unsigned pow_entry(longint unsigned i, longint unsigned n,
                                                  int frac);
        longint unsigned b;
        longint unsigned q;
        longint unsigned y;
        b = 2 * n;
        q = udiv((i * i) << 40, b * b);
        y = fifth_root(q << 20);
        return udiv(((64'd1 << frac) * i) * y, b * 64'd4096);
    endfunction

endpackage
`default_nettype wire

/* design/lcalc_div.sv */
`default_nettype none
module lcalc_div #(
    parameter int FRACTION_BITS = lcalc_pkg::DEF_FRAC
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire lcalc_pkg::side_t             in_side,
    output logic                              out_valid,
    output lcalc_pkg::side_t                  out_side,
    output logic [FRACTION_BITS-1:0]          quotient
);
    localparam int CW = lcalc_pkg::CNT_W;
    localparam int F  = FRACTION_BITS;

    logic                  valid_reg [F+1];
    lcalc_pkg::side_t      side_reg  [F+1];
    logic [CW-1:0]         rem_reg   [F+1];
    logic [F-1:0]          quo_reg   [F+1];

    // stage 0 view of the incoming item; remainder starts at CH1
    always_comb
    begin
        valid_reg[0] = in_valid;
        side_reg[0]  = in_side;
        rem_reg[0]   = in_side.c1;
        quo_reg[0]   = '0;
    end

    for (genvar g = 0; g < F; g++) begin : g_stage
        logic [CW:0] trial;
        logic        ge;
        assign trial = {rem_reg[g], 1'b0};
        assign ge    = trial >= {1'b0, side_reg[g].c0};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[g+1] <= 1'b0;
            else
                valid_reg[g+1] <= valid_reg[g];
        end

        always_ff @(posedge clk)
        begin
            side_reg[g+1] <= side_reg[g];
            rem_reg[g+1]  <= ge ? CW'(trial - {1'b0, side_reg[g].c0}) : CW'(trial);
            quo_reg[g+1]  <= {quo_reg[g][F-2:0], ge};
        end
    end

    assign out_valid = valid_reg[F];
    assign out_side  = side_reg[F];
    assign quotient  = quo_reg[F];

endmodule
`default_nettype wire

/* design/lcalc_post.sv */
`default_nettype none
module lcalc_post #(
    parameter int POWER_TABLE_ENTRIES = lcalc_pkg::DEF_ENTRIES,
    parameter int FRACTION_BITS       = lcalc_pkg::DEF_FRAC
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire lcalc_pkg::side_t       in_side,
    input  wire logic [FRACTION_BITS-1:0] quotient,
    output logic                        done,
    output lcalc_pkg::result_t          result
);
    localparam int F    = FRACTION_BITS;
    localparam int N    = POWER_TABLE_ENTRIES;
    localparam int CW   = lcalc_pkg::CNT_W;
    localparam int KW   = lcalc_pkg::KW;
    localparam int CB   = lcalc_pkg::COEF_BITS;
    localparam int LW   = lcalc_pkg::LUX_W;
    localparam int AW   = $clog2(N + 1);
    localparam int XW   = $clog2(2 * N + 1);
    localparam int PW   = F + XW;
    localparam int MW   = KW + CW;
    localparam int VW   = MW + F + 2;
    localparam int UW   = VW - CB;
    localparam logic [XW-1:0] POS_MULT = XW'(2 * N);
    localparam logic [XW-1:0] LAST_IDX = XW'(N);

    logic [F-1:0] tab [N+1];
    for (genvar g = 0; g <= N; g++) begin : g_tab
        assign tab[g] = F'(lcalc_pkg::pow_entry(longint'(g), longint'(N), F));
    end

    // stage 1: table lookup
    logic [PW-1:0] pos;
    logic [XW-1:0] idx;
    logic          last;
    logic [AW-1:0] ti;
    logic [F-1:0]  t0;
    logic [F-1:0]  t1;

    assign pos  = PW'(quotient) * PW'(POS_MULT);
    assign idx  = pos[PW-1:F];
    assign last = idx >= LAST_IDX;
    assign ti   = last ? AW'(N) : AW'(idx);
    assign t0   = tab[ti];
    assign t1   = last ? tab[AW'(N)] : tab[AW'(ti + AW'(1))];

    logic             v1_reg;
    lcalc_pkg::side_t s1_reg;
    logic [F-1:0]     t0_reg;
    logic [F-1:0]     d_reg;
    logic [F-1:0]     frac_reg;

    // stage 2: interpolation and coefficient products
    logic [2*F-1:0]  dprod;
    logic [F:0]      p_next;
    logic [KW-1:0]   ka;
    logic [KW-1:0]   kb;

    assign dprod  = d_reg * frac_reg;
    assign p_next = (F+1)'(t0_reg) + (F+1)'(dprod >> F);

    always_comb
    begin
        unique case (s1_reg.band)
            lcalc_pkg::BAND_MID:
            begin
                ka = lcalc_pkg::K_B2_CH0;
                kb = lcalc_pkg::K_B2_CH1;
            end
            lcalc_pkg::BAND_HIGH:
            begin
                ka = lcalc_pkg::K_B3_CH0;
                kb = lcalc_pkg::K_B3_CH1;
            end
            lcalc_pkg::BAND_TOP:
            begin
                ka = lcalc_pkg::K_B4_CH0;
                kb = lcalc_pkg::K_B4_CH1;
            end
            default:
            begin
                ka = '0;
                kb = '0;
            end
        endcase
    end

    logic             v2_reg;
    lcalc_pkg::side_t s2_reg;
    logic [F:0]       p_reg;
    logic [MW-1:0]    a1_reg;
    logic [MW-1:0]    la_reg;
    logic [MW-1:0]    lb_reg;

    // stage 3: CH0 * power term, linear difference
    logic             v3_reg;
    lcalc_pkg::side_t s3_reg;
    logic [CW+F:0]    cp_reg;
    logic signed [VW-1:0] a1s_reg;
    logic signed [VW-1:0] lin_reg;

    logic signed [MW:0] lin_diff;
    assign lin_diff = $signed({1'b0, la_reg}) - $signed({1'b0, lb_reg});

    // stage 4: final difference, clamp and saturate
    logic [KW+CW+F:0]     pw_term;
    logic signed [VW-1:0] v1;
    logic signed [VW-1:0] v;
    logic [UW-1:0]        u;
    lcalc_pkg::result_t   res_next;

    assign pw_term = (KW+CW+F+1)'(lcalc_pkg::K_B1_POW) * (KW+CW+F+1)'(cp_reg);
    assign v1      = a1s_reg - $signed(VW'(pw_term));
    assign u       = UW'(v >>> CB);

    always_comb
    begin
        unique case (s3_reg.band)
            lcalc_pkg::BAND_LOW:  v = v1;
            lcalc_pkg::BAND_MID,
            lcalc_pkg::BAND_HIGH,
            lcalc_pkg::BAND_TOP:  v = lin_reg;
            default:              v = '0;
        endcase
        res_next.ratio_band = s3_reg.band;
        if (v <= 0)
            res_next.lux_value = '0;
        else if (u > UW'(lcalc_pkg::LUX_MAX))
            res_next.lux_value = lcalc_pkg::LUX_MAX;
        else
            res_next.lux_value = LW'(u);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            done   <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            done   <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg   <= in_side;
        t0_reg   <= t0;
        d_reg    <= (last || t1 < t0) ? '0 : F'(t1 - t0);
        frac_reg <= last ? '0 : pos[F-1:0];

        s2_reg   <= s1_reg;
        p_reg    <= p_next;
        a1_reg   <= MW'(lcalc_pkg::K_B1_CH0) * MW'(s1_reg.c0);
        la_reg   <= MW'(ka) * MW'(s1_reg.c0);
        lb_reg   <= MW'(kb) * MW'(s1_reg.c1);

        s3_reg   <= s2_reg;
        cp_reg   <= (CW+F+1)'(s2_reg.c0) * (CW+F+1)'(p_reg);
        a1s_reg  <= $signed(VW'(a1_reg) << F);
        lin_reg  <= $signed(VW'(lin_diff)) <<< F;

        result   <= res_next;
    end

endmodule
`default_nettype wire

/* design/ambient_light_lux_calc.sv */
`default_nettype none
// Two-channel photodiode lux calculator.
//
// Input channel: present a sample (broadband CH0 and infrared CH1 counts)
// with start high; it is transferred at the rising edge where start is high
// and busy is low. busy is always low, so a new sample may be transferred
// in every cycle: throughput is one sample per clock.
// Output channel: each result (lux with FRACTION_BITS fractional bits and a
// ratio band code) is shown on result for exactly one cycle with done high,
// after its sample has passed one input stage, one restoring divider stage
// per quotient bit and four lookup/multiply stages.
// The divider produces one quotient bit per stage.
// The receiver cannot stall: it must take each result in its done cycle.
// Band codes: 0 a count is zero, 1 to 4 the ratio bands, 5 ratio above 1.3.
// Reset clears every valid bit, so no result appears until samples arrive;
// the power table is a constant ROM and needs no fill after reset.
module ambient_light_lux_calc #(
    parameter int POWER_TABLE_ENTRIES = lcalc_pkg::DEF_ENTRIES,
    parameter int FRACTION_BITS       = lcalc_pkg::DEF_FRAC
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire lcalc_pkg::sample_t  sample,
    output logic                     done,
    output lcalc_pkg::result_t       result
);
    localparam int CW  = lcalc_pkg::CNT_W;
    localparam int LAT = FRACTION_BITS + 5;

    // never hold the sender off
    assign busy = 1'b0;

    // band selection by exact cross-multiplied comparisons
    logic [CW-1:0]            c0;
    logic [CW-1:0]            c1;
    logic [CW+6:0]            m0_61;
    logic [CW+6:0]            m1_100;
    logic [lcalc_pkg::BAND_W-1:0] band_next;

    assign c0     = sample.broadband_count;
    assign c1     = sample.infrared_count;
    assign m0_61  = (CW+7)'(c0) * (CW+7)'(61);
    assign m1_100 = (CW+7)'(c1) * (CW+7)'(100);

    always_comb
    begin
        priority if (c0 == '0 || c1 == '0)
            band_next = lcalc_pkg::BAND_ZERO;
        else if ({c1, 1'b0} <= {1'b0, c0})
            band_next = lcalc_pkg::BAND_LOW;
        else if (m1_100 <= m0_61)
            band_next = lcalc_pkg::BAND_MID;
        else if ((CW+3)'(c1) * (CW+3)'(5) <= (CW+3)'(c0) * (CW+3)'(4))
            band_next = lcalc_pkg::BAND_HIGH;
        else if ((CW+4)'(c1) * (CW+4)'(10) <= (CW+4)'(c0) * (CW+4)'(13))
            band_next = lcalc_pkg::BAND_TOP;
        else
            band_next = lcalc_pkg::BAND_OVER;
    end

    // input stage: hold the transferred sample and its band
    logic             in_valid_reg;
    lcalc_pkg::side_t in_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        in_side_reg.c0   <= c0;
        in_side_reg.c1   <= c1;
        in_side_reg.band <= band_next;
    end

    logic                     div_valid;
    lcalc_pkg::side_t         div_side;
    logic [FRACTION_BITS-1:0] div_quo;

    lcalc_div #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid_reg),
        .in_side  (in_side_reg),
        .out_valid(div_valid),
        .out_side (div_side),
        .quotient (div_quo)
    );

    lcalc_post #(
        .POWER_TABLE_ENTRIES(POWER_TABLE_ENTRIES),
        .FRACTION_BITS      (FRACTION_BITS)
    ) u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (div_valid),
        .in_side  (div_side),
        .quotient (div_quo),
        .done     (done),
        .result   (result)
    );

    // every result traces back to a transfer a fixed latency earlier
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a matching transfer");

    // zero count and out-of-range bands never carry lux
    a_zero_band: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.ratio_band == lcalc_pkg::BAND_ZERO ||
                  result.ratio_band == lcalc_pkg::BAND_OVER)) |-> result.lux_value == '0)
        else $error("lux on a zero or over-range band");

    // a zero broadband count at transfer yields the zero band code
    a_band_known: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(sample.broadband_count, LAT) == '0) |->
            result.ratio_band == lcalc_pkg::BAND_ZERO)
        else $error("zero broadband count not flagged");

endmodule
`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb;

    localparam int ENTRIES  = lcalc_pkg::DEF_ENTRIES;
    localparam int FRAC     = lcalc_pkg::DEF_FRAC;
    localparam int LATENCY  = FRAC + 5;
    localparam int WDOG_MAX = 2000;
    localparam int N_RANDOM = 800;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    lcalc_pkg::sample_t sample;
    logic               done;
    lcalc_pkg::result_t result;

    ambient_light_lux_calc dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .sample (sample),
        .done   (done),
        .result (result)
    );

    // Pending samples for the driver, and results awaited by the checker.
    lcalc_pkg::sample_t pending_samples[$];
    lcalc_pkg::result_t expected_lux[$];
    longint unsigned x14_rom[ENTRIES + 1];
    int  mismatches;
    int  quiet_cycles;
    bit  stim_done;
    bit  hold_for_drain;
    int  burst_left;
    int  gap_left;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Build the x^1.4 ROM independently: binary-search fifth root, plain division.
    initial
    begin
        longint unsigned b, q, n, lo, hi, m;
        b = 2 * ENTRIES;
        for (int i = 0; i <= ENTRIES; i++)
        begin
            q  = ((longint'(i) * i) << 40) / (b * b);
            n  = q << 20;
            lo = 0;
            hi = 4096;
            while (lo < hi)
            begin
                m = (lo + hi + 1) / 2;
                if (m * m * m * m * m <= n)
                    lo = m;
                else
                    hi = m - 1;
            end
            x14_rom[i] = ((64'd1 << FRAC) * i * lo) / (b * 4096);
        end
    end

    // Scale a Q.(24+FRAC) difference down to lux, clamping below zero and above full scale.
    function automatic logic [lcalc_pkg::LUX_W-1:0] lux_of(longint v);
        longint unsigned u;
        if (v <= 0)
            return '0;
        u = longint'(v) >>> lcalc_pkg::COEF_BITS;
        return (u > lcalc_pkg::LUX_MAX) ? lcalc_pkg::LUX_MAX : u[lcalc_pkg::LUX_W-1:0];
    endfunction

    function automatic lcalc_pkg::result_t predict_lux(lcalc_pkg::sample_t s);
        lcalc_pkg::result_t r;
        longint unsigned    c0, c1, ratio, pos, idx, fr, p, d, ka, kb;
        longint             v;
        c0 = s.broadband_count;
        c1 = s.infrared_count;
        r.lux_value  = '0;
        r.ratio_band = lcalc_pkg::BAND_ZERO;
        if (c0 == 0 || c1 == 0)
            return r;
        if (2 * c1 <= c0)
        begin
            ratio = (c1 << FRAC) / c0;
            pos   = ratio * (2 * ENTRIES);
            idx   = pos >> FRAC;
            fr    = pos & ((64'd1 << FRAC) - 1);
            if (idx >= ENTRIES)
                p = x14_rom[ENTRIES];
            else
            begin
                d = (x14_rom[idx + 1] >= x14_rom[idx]) ? x14_rom[idx + 1] - x14_rom[idx] : 0;
                p = x14_rom[idx] + ((d * fr) >> FRAC);
            end
            v = longint'((longint'(lcalc_pkg::K_B1_CH0) * c0) << FRAC)
              - longint'(lcalc_pkg::K_B1_POW * c0 * p);
            r.ratio_band = lcalc_pkg::BAND_LOW;
            r.lux_value  = lux_of(v);
            return r;
        end
        if (100 * c1 <= 61 * c0)
        begin
            r.ratio_band = lcalc_pkg::BAND_MID;
            ka = lcalc_pkg::K_B2_CH0;
            kb = lcalc_pkg::K_B2_CH1;
        end
        else if (5 * c1 <= 4 * c0)
        begin
            r.ratio_band = lcalc_pkg::BAND_HIGH;
            ka = lcalc_pkg::K_B3_CH0;
            kb = lcalc_pkg::K_B3_CH1;
        end
        else if (10 * c1 <= 13 * c0)
        begin
            r.ratio_band = lcalc_pkg::BAND_TOP;
            ka = lcalc_pkg::K_B4_CH0;
            kb = lcalc_pkg::K_B4_CH1;
        end
        else
        begin
            r.ratio_band = lcalc_pkg::BAND_OVER;
            return r;
        end
        v = longint'(ka * c0) - longint'(kb * c1);
        if (v > 0)
            r.lux_value = lux_of(v <<< FRAC);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        mismatches++;
    endtask

    function automatic void queue_pair(int c0, int c1);
        lcalc_pkg::sample_t s;
        s.broadband_count = c0[lcalc_pkg::CNT_W-1:0];
        s.infrared_count  = c1[lcalc_pkg::CNT_W-1:0];
        pending_samples.push_back(s);
    endfunction

    // Pick a CH1 value for a given CH0 that lands near a band boundary ratio num/den.
    function automatic int near_ratio(int c0, int num, int den);
        int c1;
        c1 = (c0 * num) / den + $urandom_range(0, 2) - 1;
        if (c1 < 1) c1 = 1;
        if (c1 > 65535) c1 = 65535;
        return c1;
    endfunction

    initial
    begin
        int c0, c1, sel;
        // Directed: zero counts, field extremes, each band and its edges, above 1.3.
        queue_pair(0, 0);
        queue_pair(0, 65535);
        queue_pair(65535, 0);
        queue_pair(1, 1);
        queue_pair(65535, 65535);
        queue_pair(65535, 1);
        queue_pair(2, 1);        // exactly 0.5
        queue_pair(100, 61);     // exactly 0.61
        queue_pair(100, 62);
        queue_pair(5, 4);        // exactly 0.8
        queue_pair(10, 13);      // exactly 1.3
        queue_pair(10, 14);      // just above 1.3
        queue_pair(1, 65535);
        queue_pair(65535, 32767);
        queue_pair(65535, 32768);
        queue_pair(40000, 30000);
        queue_pair(50000, 55000);
        queue_pair(65535, 40000);
        queue_pair(21845, 43690);
        queue_pair(43690, 21845);
        for (int k = 0; k < N_RANDOM; k++)
        begin
            c0  = $urandom_range(1, 65535);
            sel = $urandom_range(0, 9);
            case (sel)
                0: c1 = near_ratio(c0, 1, 2);
                1: c1 = near_ratio(c0, 61, 100);
                2: c1 = near_ratio(c0, 4, 5);
                3: c1 = near_ratio(c0, 13, 10);
                4: begin c0 = $urandom_range(0, 65535); c1 = $urandom_range(0, 65535); end
                5: c1 = $urandom_range(1, (c0 + 1) / 2);
                6: c1 = $urandom_range(0, 3);
                default: c1 = $urandom_range(1, (c0 * 13 / 10 > 65535) ? 65535 : c0 * 13 / 10 + 1);
            endcase
            queue_pair(c0, c1);
        end
        stim_done = 1'b1;
    end

    // Driver: bursts and gaps; once, hold until everything in flight has drained.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            sample     <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (start && !busy)
                expected_lux.push_back(predict_lux(sample));
            if (hold_for_drain && (expected_lux.size() != 0 || (start && !busy)))
                start <= 1'b0;
            else if (gap_left > 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (start && busy)
                start <= 1'b1;
            else if (pending_samples.size() == 0)
                start <= 1'b0;
            else
            begin
                sample <= pending_samples.pop_front();
                start  <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // Monitor: take each result in its strobe cycle and compare with the oldest prediction.
    always @(posedge clk)
    begin
        lcalc_pkg::result_t want;
        if (rst_n && done)
        begin
            if (expected_lux.size() == 0)
                report_mismatch("unexpected result, lux", result.lux_value, 0);
            else
            begin
                want = expected_lux.pop_front();
                if (result.lux_value != want.lux_value)
                    report_mismatch("lux_value", result.lux_value, want.lux_value);
                if (result.ratio_band != want.ratio_band)
                    report_mismatch("ratio_band", result.ratio_band, want.ratio_band);
            end
        end
    end

    // Watchdog: count cycles with no transfer in either direction.
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX)
        begin
            $display("watchdog expired");
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        mismatches     = 0;
        quiet_cycles   = 0;
        hold_for_drain = 1'b0;
        start          = 1'b0;
        sample         = '0;
        rst_n          = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // Once, mid-run, stop sending until every prediction has been matched.
        wait (pending_samples.size() < 500);
        @(posedge clk);
        hold_for_drain = 1'b1;
        wait (expected_lux.size() == 0 && !start);
        repeat (3) @(posedge clk);
        hold_for_drain = 1'b0;
        wait (stim_done && pending_samples.size() == 0);
        @(posedge clk);
        wait (!start);
        @(posedge clk);
        wait (expected_lux.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && expected_lux.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
